FILE: rtl/pctd_pkg.sv
`timescale 1ns / 1ps
// pctd_pkg: shared types and constants for the trial division prime counter
// used by pctd_rem, prime_count_trial_division_core and pctd_chk; no dependencies

package pctd_pkg;

    localparam int unsigned DEFAULT_VALUE_WIDTH = 16;
    localparam int unsigned CMD_WIDTH           = 3;
    localparam int unsigned ANSWER_WIDTH        = 16;

    localparam logic [ANSWER_WIDTH-1:0] ANSWER_MAX = '1;

    // command codes
    localparam logic [CMD_WIDTH-1:0] CMD_COUNT_ALL   = 3'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_COUNT_1MOD4 = 3'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_COUNT_3MOD4 = 3'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_COUNT_SAFE  = 3'd3;
    localparam logic [CMD_WIDTH-1:0] CMD_TEST_PRIME  = 3'd4;
    localparam logic [CMD_WIDTH-1:0] CMD_TEST_SAFE   = 3'd5;

    // status from the remainder unit back to the sequencer
    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_status;

endpackage

FILE: rtl/pctd_rem.sv
`timescale 1ns / 1ps
// pctd_rem: bit-serial restoring remainder unit, one dividend bit per cycle
// depends on pctd_pkg

module pctd_rem #(
    parameter int unsigned VALUE_WIDTH = pctd_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [VALUE_WIDTH-1:0]  i_dividend,
    input  logic [VALUE_WIDTH-1:0]  i_divisor,
    output pctd_pkg::t_rem_status   o_status
);

    localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

    logic                   r_busy, n_busy;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [VALUE_WIDTH-1:0] r_dvd, n_dvd;
    logic [VALUE_WIDTH-1:0] r_dvs, n_dvs;
    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic                   r_done, n_done;
    logic                   r_zero, n_zero;

    logic [VALUE_WIDTH:0]   w_trial;
    logic [VALUE_WIDTH:0]   w_diff;
    logic [VALUE_WIDTH-1:0] w_step;

    // shift in the next dividend bit, subtract the divisor when it fits
    assign w_trial = {r_rem, r_dvd[VALUE_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_step  = (w_trial >= {1'b0, r_dvs}) ? w_diff[VALUE_WIDTH-1:0]
                                                 : w_trial[VALUE_WIDTH-1:0];

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        n_done = 1'b0;
        n_zero = r_zero;
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(VALUE_WIDTH - 1);
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = w_step;
            n_dvd = {r_dvd[VALUE_WIDTH-2:0], 1'b0};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_zero = (w_step == '0);
            end else begin
                n_cnt = r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_zero <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_zero <= n_zero;
        end
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

    assign o_status.done = r_done;
    assign o_status.zero = r_zero;

endmodule

FILE: rtl/prime_count_trial_division_core.sv
`timescale 1ns / 1ps
// prime_count_trial_division_core: top level, command sequencer around one
// shared remainder unit; depends on pctd_pkg and pctd_rem

// Prime counter and primality tester by trial division. A command word is
// taken when start is high and busy is low; commands 0 to 3 count primes up
// to the value (all, 1 mod 4, 3 mod 4, safe primes), 4 and 5 test the value
// for prime or safe prime and answer 1 or 0, and 6 and 7 answer 0. Exactly one
// answer comes back on o_answer, marked by o_valid for one cycle; it cannot be
// held off, so the receiver must take it then. Counts saturate at 65535.
// Timing is data dependent and set by the single bit-serial remainder unit:
// each trial divisor costs a compare, one dividend bit per cycle in the
// remainder unit and a hand-back of the result; a candidate n tries at most
// floor(sqrt(n)) - 1 divisors, with a select, a set-up and a verdict step
// around them and a last compare when no divisor is found and ends the
// search, and a safe prime test repeats this for (n-1)/2. Commands 6 and 7,
// and a count of all primes below 2, answer in the cycle after the command
// word.

module prime_count_trial_division_core #(
    parameter int unsigned VALUE_WIDTH = pctd_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pctd_pkg::CMD_WIDTH-1:0]    i_command,
    input  logic [VALUE_WIDTH-1:0]            i_value,
    output logic                              o_valid,
    output logic [pctd_pkg::ANSWER_WIDTH-1:0] o_answer
);

    localparam int unsigned W  = VALUE_WIDTH;
    localparam int unsigned AW = pctd_pkg::ANSWER_WIDTH;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,  // waiting for a command word
        ST_CAND  = 6'b000010,  // next candidate or finish the count
        ST_INIT  = 6'b000100,  // set up trial division for r_n
        ST_CHECK = 6'b001000,  // d*d > n ends the search, else divide
        ST_DIV   = 6'b010000,  // waiting on the remainder unit
        ST_VERD  = 6'b100000   // act on the verdict for r_n
    } t_state;

    t_state                r_state, n_state;
    logic                  r_valid, n_valid;
    logic [AW-1:0]         r_answer, n_answer;
    logic [W-1:0]          r_limit, n_limit;     // counting limit
    logic [W:0]            r_cand, n_cand;       // one spare bit for overshoot
    logic [AW-1:0]         r_count, n_count;     // saturating prime count
    logic [W-1:0]          r_n, n_n;             // number under test
    logic [W-1:0]          r_d, n_d;             // trial divisor
    logic [W+1:0]          r_sq, n_sq;           // d squared, kept by adding 2d+1
    logic                  r_verdict, n_verdict;
    logic                  r_stage, n_stage;     // testing (n-1)/2 of a safe prime
    logic                  r_safe, n_safe;
    logic                  r_single, n_single;   // test command, one candidate
    logic                  r_stride4, n_stride4; // step candidates by 4, else 2

    logic                  w_rem_start;
    pctd_pkg::t_rem_status w_rem_st;

    pctd_rem #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (r_n),
        .i_divisor  (r_d),
        .o_status   (w_rem_st)
    );

    // launch a division whenever d*d still fits under n
    assign w_rem_start = (r_state == ST_CHECK) && !(r_sq > {2'b00, r_n});

    always_comb begin
        n_state   = r_state;
        n_valid   = 1'b0;
        n_answer  = r_answer;
        n_limit   = r_limit;
        n_cand    = r_cand;
        n_count   = r_count;
        n_n       = r_n;
        n_d       = r_d;
        n_sq      = r_sq;
        n_verdict = r_verdict;
        n_stage   = r_stage;
        n_safe    = r_safe;
        n_single  = r_single;
        n_stride4 = r_stride4;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_limit   = i_value;
                    n_count   = '0;
                    n_stage   = 1'b0;
                    n_safe    = 1'b0;
                    n_single  = 1'b0;
                    n_stride4 = 1'b0;
                    n_state   = ST_CAND;
                    case (i_command)
                        pctd_pkg::CMD_COUNT_ALL: begin
                            // 2 is counted up front, odd numbers from 3 after
                            if (i_value < W'(2)) begin
                                n_valid  = 1'b1;
                                n_answer = '0;
                                n_state  = ST_IDLE;
                            end else begin
                                n_count = AW'(1);
                                n_cand  = (W+1)'(3);
                            end
                        end
                        pctd_pkg::CMD_COUNT_1MOD4: begin
                            n_cand    = (W+1)'(5);
                            n_stride4 = 1'b1;
                        end
                        pctd_pkg::CMD_COUNT_3MOD4: begin
                            n_cand    = (W+1)'(3);
                            n_stride4 = 1'b1;
                        end
                        pctd_pkg::CMD_COUNT_SAFE: begin
                            n_cand = (W+1)'(5);
                            n_safe = 1'b1;
                        end
                        pctd_pkg::CMD_TEST_PRIME: begin
                            n_cand   = {1'b0, i_value};
                            n_single = 1'b1;
                        end
                        pctd_pkg::CMD_TEST_SAFE: begin
                            n_cand   = {1'b0, i_value};
                            n_single = 1'b1;
                            n_safe   = 1'b1;
                        end
                        default: begin
                            // unused commands answer zero at once
                            n_valid  = 1'b1;
                            n_answer = '0;
                            n_state  = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CAND: begin
                if (r_cand > {1'b0, r_limit}) begin
                    n_valid  = 1'b1;
                    n_answer = r_count;
                    n_state  = ST_IDLE;
                end else begin
                    n_n     = r_cand[W-1:0];
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                // 0 and 1 are not prime
                if (r_n < W'(2)) begin
                    n_verdict = 1'b0;
                    n_state   = ST_VERD;
                end else begin
                    n_d     = W'(2);
                    n_sq    = (W+2)'(4);
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_sq > {2'b00, r_n}) begin
                    n_verdict = 1'b1;
                    n_state   = ST_VERD;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_rem_st.done) begin
                    if (w_rem_st.zero) begin
                        n_verdict = 1'b0;
                        n_state   = ST_VERD;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        n_d     = r_d + W'(1);
                        n_sq    = r_sq + {1'b0, r_d, 1'b1};
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_VERD: begin
                if (r_verdict && r_safe && !r_stage) begin
                    // prime so far, now test (n-1)/2
                    n_n     = W'((r_n - W'(1)) >> 1);
                    n_stage = 1'b1;
                    n_state = ST_INIT;
                end else begin
                    n_stage = 1'b0;
                    if (r_single) begin
                        n_valid  = 1'b1;
                        n_answer = {{(AW-1){1'b0}}, r_verdict};
                        n_state  = ST_IDLE;
                    end else begin
                        if (r_verdict && (r_count != pctd_pkg::ANSWER_MAX)) begin
                            n_count = r_count + AW'(1);
                        end
                        n_cand  = r_cand + (r_stride4 ? (W+1)'(4) : (W+1)'(2));
                        n_state = ST_CAND;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_answer  <= n_answer;
        r_limit   <= n_limit;
        r_cand    <= n_cand;
        r_count   <= n_count;
        r_n       <= n_n;
        r_d       <= n_d;
        r_sq      <= n_sq;
        r_verdict <= n_verdict;
        r_stage   <= n_stage;
        r_safe    <= n_safe;
        r_single  <= n_single;
        r_stride4 <= n_stride4;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_answer = r_answer;

endmodule

FILE: rtl/pctd_chk.sv
`timescale 1ns / 1ps
// pctd_chk: port-level checker for prime_count_trial_division_core, with bind
// depends on pctd_pkg

module pctd_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_start,
    input logic                              i_busy,
    input logic [pctd_pkg::CMD_WIDTH-1:0]    i_command,
    input logic                              i_valid,
    input logic [pctd_pkg::ANSWER_WIDTH-1:0] i_answer
);

    logic                           r_test;
    logic                           w_accept;

    assign w_accept = i_start && !i_busy;

    // remember whether the word in flight is a test command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_test <= 1'b0;
        end else if (w_accept) begin
            r_test <= (i_command == pctd_pkg::CMD_TEST_PRIME) ||
                      (i_command == pctd_pkg::CMD_TEST_SAFE);
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid && !i_busy)
        else $error("valid or busy set after reset");

    a_unused_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_command > pctd_pkg::CMD_TEST_SAFE)
        |=> i_valid && (i_answer == '0))
        else $error("unused command did not answer zero at once");

    a_work_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_command != pctd_pkg::CMD_COUNT_ALL) &&
        (i_command <= pctd_pkg::CMD_TEST_SAFE)
        |=> i_busy && !i_valid)
        else $error("working command did not raise busy");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !i_busy)
        else $error("answer shown while still busy");

    a_test_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && r_test |-> (i_answer <= pctd_pkg::ANSWER_WIDTH'(1)))
        else $error("test answer is not 0 or 1");

endmodule

bind prime_count_trial_division_core pctd_chk u_pctd_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_start   (start),
    .i_busy    (busy),
    .i_command (i_command),
    .i_valid   (o_valid),
    .i_answer  (o_answer)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for prime_count_trial_division_core, directed
// table then random words; depends on pctd_pkg and the core rtl

module testbench;

    localparam int unsigned CMD_W = pctd_pkg::CMD_WIDTH;
    localparam int unsigned ANS_W = pctd_pkg::ANSWER_WIDTH;

    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam int unsigned VAL_W       = pctd_pkg::DEFAULT_VALUE_WIDTH;
    localparam int          N_DIRECTED  = 25;
    localparam int          N_RANDOM    = 75;
    localparam int          N_CALM_TAIL = 20;
    localparam int          DRAIN_WAIT  = 64;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] value;
        bit               typed;
        logic [ANS_W-1:0] answer;
    } t_stim_row;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] value;
        logic [ANS_W-1:0] answer;
    } t_answer_expect;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [CMD_W-1:0] i_command;
    logic [VAL_W-1:0] i_value;
    logic             o_valid;
    logic [ANS_W-1:0] o_answer;

    t_answer_expect pending_answers[$];
    t_stim_row      directed_rows[N_DIRECTED];

    int          error_count;
    int          answers_checked;
    int          words_sent;
    int          words_per_cmd[8];
    longint      cycle_count = 0;
    longint      cycle_deadline;

    prime_count_trial_division_core #(
        .VALUE_WIDTH(VAL_W)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_command(i_command),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .o_answer (o_answer)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // answer predictor
    // ------------------------------------------------------------------

    function automatic bit prime_by_trial(int unsigned n);
        int unsigned d;
        if (n < 2) return 1'b0;
        for (d = 2; d * d <= n; d++) begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // safe prime: p prime and (p-1)/2 prime as well
    function automatic bit safe_by_trial(int unsigned n);
        if (!prime_by_trial(n)) return 1'b0;
        return prime_by_trial((n - 1) / 2);
    endfunction

    function automatic logic [ANS_W-1:0] predicted_answer(
        logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] value);
        int unsigned n;
        int unsigned first;
        int unsigned stride;
        int unsigned hits;
        bit          want_safe;
        hits      = 0;
        want_safe = 1'b0;
        case (cmd)
            pctd_pkg::CMD_COUNT_ALL: begin
                first  = 2;
                stride = 1;
            end
            pctd_pkg::CMD_COUNT_1MOD4: begin
                first  = 5;
                stride = 4;
            end
            pctd_pkg::CMD_COUNT_3MOD4: begin
                first  = 3;
                stride = 4;
            end
            pctd_pkg::CMD_COUNT_SAFE: begin
                first     = 5;
                stride    = 1;
                want_safe = 1'b1;
            end
            pctd_pkg::CMD_TEST_PRIME: return prime_by_trial(32'(value)) ? 16'd1 : 16'd0;
            pctd_pkg::CMD_TEST_SAFE:  return safe_by_trial(32'(value)) ? 16'd1 : 16'd0;
            default:                  return '0;
        endcase
        for (n = first; n <= value; n += stride) begin
            if (want_safe ? safe_by_trial(n) : prime_by_trial(n)) begin
                if (hits < pctd_pkg::ANSWER_MAX) hits++;
            end
        end
        return hits[ANS_W-1:0];
    endfunction

    // generous upper bound on the core's cycles for one word: every candidate
    // tries every divisor up to its root, twice over for the safe check
    function automatic longint word_cycle_bound(logic [CMD_W-1:0] cmd,
                                                logic [VAL_W-1:0] value);
        longint root;
        longint cands;
        root = 1;
        while (root * root <= value) root++;
        cands = (cmd inside {pctd_pkg::CMD_COUNT_ALL, pctd_pkg::CMD_COUNT_1MOD4,
                             pctd_pkg::CMD_COUNT_3MOD4, pctd_pkg::CMD_COUNT_SAFE})
                ? longint'(value) + 1 : 1;
        return cands * (root + 2) * (VAL_W + 5) * 2 + 32;
    endfunction

    // first prime (or safe prime) at or above a random point, so that true
    // answers turn up often in the random tests
    function automatic logic [VAL_W-1:0] next_hit_from(int unsigned from,
                                                       bit want_safe);
        int unsigned n;
        for (n = from; n < (1 << VAL_W); n++) begin
            if (want_safe ? safe_by_trial(n) : prime_by_trial(n)) return n[VAL_W-1:0];
        end
        return 16'd5;
    endfunction

    // ------------------------------------------------------------------
    // answer checker: each o_valid cycle is one answer word, no back-pressure
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_answer_expect exp_word;
        if (i_rst_n && o_valid) begin
            if (pending_answers.size() == 0) begin
                $error("unexpected answer word %0d with nothing outstanding", o_answer);
                error_count++;
            end else begin
                exp_word = pending_answers.pop_front();
                answers_checked++;
                if (o_answer !== exp_word.answer) begin
                    $error("answer: expected %0d, actual %0d (command %0d value %0d)",
                           exp_word.answer, o_answer, exp_word.cmd, exp_word.value);
                    error_count++;
                end
            end
        end
    end

    // watchdog: the deadline grows with the bound of every word sent
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_deadline) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // word driver, entered and left at a falling edge
    // ------------------------------------------------------------------

    task automatic send_word(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] value,
                             bit typed, logic [ANS_W-1:0] typed_answer);
        t_answer_expect exp_word;
        start     <= 1'b1;
        i_command <= cmd;
        i_value   <= value;
        cycle_deadline += 4 * word_cycle_bound(cmd, value) + 64;
        // hold the word until the core takes it
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        exp_word.cmd    = cmd;
        exp_word.value  = value;
        exp_word.answer = typed ? typed_answer : predicted_answer(cmd, value);
        pending_answers.push_back(exp_word);
        words_sent++;
        words_per_cmd[cmd]++;
        @(negedge i_clk);
    endtask

    // idle burst on the command side with junk on the payload
    task automatic idle_burst();
        int n;
        n = $urandom_range(1, 8);
        start     <= 1'b0;
        i_command <= CMD_W'($urandom);
        i_value   <= VAL_W'($urandom);
        repeat (n) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] value;
        int               pick;
        bit               calm;

        error_count     = 0;
        answers_checked = 0;
        words_sent      = 0;
        cycle_deadline  = 20000;
        foreach (words_per_cmd[k]) words_per_cmd[k] = 0;

        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_command <= '0;
        i_value   <= '0;

        // small values, the non-safe 2 and 3, the first safe prime 5, the
        // largest 16 bit prime, all-ones values and the two spare commands;
        // counts stay far below full range
        directed_rows = '{
            '{pctd_pkg::CMD_COUNT_ALL,   16'd0,     1'b1, 16'd0},
            '{pctd_pkg::CMD_COUNT_ALL,   16'd1,     1'b1, 16'd0},
            '{pctd_pkg::CMD_COUNT_ALL,   16'd2,     1'b1, 16'd1},
            '{pctd_pkg::CMD_COUNT_ALL,   16'd3,     1'b1, 16'd2},
            '{pctd_pkg::CMD_COUNT_1MOD4, 16'd4,     1'b1, 16'd0},
            '{pctd_pkg::CMD_COUNT_1MOD4, 16'd5,     1'b1, 16'd1},
            '{pctd_pkg::CMD_COUNT_3MOD4, 16'd2,     1'b1, 16'd0},
            '{pctd_pkg::CMD_COUNT_3MOD4, 16'd3,     1'b1, 16'd1},
            '{pctd_pkg::CMD_COUNT_SAFE,  16'd4,     1'b1, 16'd0},
            '{pctd_pkg::CMD_COUNT_SAFE,  16'd5,     1'b1, 16'd1},
            '{pctd_pkg::CMD_TEST_PRIME,  16'd0,     1'b1, 16'd0},
            '{pctd_pkg::CMD_TEST_PRIME,  16'd1,     1'b1, 16'd0},
            '{pctd_pkg::CMD_TEST_PRIME,  16'd2,     1'b1, 16'd1},
            '{pctd_pkg::CMD_TEST_PRIME,  16'hffff,  1'b1, 16'd0},
            '{pctd_pkg::CMD_TEST_PRIME,  16'd65521, 1'b1, 16'd1},
            '{pctd_pkg::CMD_TEST_SAFE,   16'd2,     1'b1, 16'd0},
            '{pctd_pkg::CMD_TEST_SAFE,   16'd3,     1'b1, 16'd0},
            '{pctd_pkg::CMD_TEST_SAFE,   16'd5,     1'b1, 16'd1},
            '{pctd_pkg::CMD_TEST_SAFE,   16'hffff,  1'b1, 16'd0},
            '{CMD_SPARE_6,               16'h5a5a,  1'b1, 16'd0},
            '{CMD_SPARE_7,               16'hffff,  1'b1, 16'd0},
            '{pctd_pkg::CMD_COUNT_ALL,   16'd1000,  1'b0, 16'd0},
            '{pctd_pkg::CMD_COUNT_1MOD4, 16'd200,   1'b0, 16'd0},
            '{pctd_pkg::CMD_COUNT_3MOD4, 16'd200,   1'b0, 16'd0},
            '{pctd_pkg::CMD_COUNT_SAFE,  16'd300,   1'b0, 16'd0}
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            if ($urandom_range(0, 3) == 0) idle_burst();
            send_word(directed_rows[r].cmd, directed_rows[r].value,
                      directed_rows[r].typed, directed_rows[r].answer);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            calm = (i >= N_RANDOM - N_CALM_TAIL);
            pick = $urandom_range(0, 19);
            if (pick < 9) begin
                // counts: mostly small limits, now and then a larger one
                cmd   = CMD_W'($urandom_range(pctd_pkg::CMD_COUNT_ALL,
                                              pctd_pkg::CMD_COUNT_SAFE));
                value = ($urandom_range(0, 15) == 0) ? VAL_W'($urandom_range(256, 1023))
                                                     : VAL_W'($urandom_range(0, 255));
            end else if (pick < 18) begin
                // tests: half full-range values, half landed on a true case
                cmd   = CMD_W'($urandom_range(pctd_pkg::CMD_TEST_PRIME,
                                              pctd_pkg::CMD_TEST_SAFE));
                value = VAL_W'($urandom);
                if ($urandom_range(0, 1) == 0)
                    value = next_hit_from(32'(value), cmd == pctd_pkg::CMD_TEST_SAFE);
            end else begin
                cmd   = CMD_W'($urandom_range(CMD_SPARE_6, CMD_SPARE_7));
                value = VAL_W'($urandom);
            end
            if (!calm && $urandom_range(0, 2) == 0) idle_burst();
            send_word(cmd, value, 1'b0, '0);
        end
        start <= 1'b0;

        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (pending_answers.size() != 0) begin
            $error("%0d answer words never arrived", pending_answers.size());
            error_count++;
        end

        $display("run: %0d words sent (%0d from the table), %0d answers checked",
                 words_sent, N_DIRECTED, answers_checked);
        $display("words per command 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 words_per_cmd[0], words_per_cmd[1], words_per_cmd[2],
                 words_per_cmd[3], words_per_cmd[4], words_per_cmd[5],
                 words_per_cmd[6], words_per_cmd[7]);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
